// ===== design/pcl_pkg.sv =====
// package for the positional character list
// holds sizes, operation and status codes and the controller state type; no dependencies
package pcl_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 8;
  localparam int CMP_W    = POS_W + 1;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_DEL   = 2'd1,
    MODE_GET   = 2'd2,
    MODE_PRINT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_INS_WR,
    S_GET,
    S_PRINT
  } state_e;

endpackage

// ===== design/pcl_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module pcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/positional_char_list.sv =====
// a rejected transaction, a delete at the tail and an empty print answer straight from idle,
// with the result registered in the cycle after accept; add moves the entries from the tail
// down to the position one by one and then writes the new character, delete moves the entries
// behind the position forward, get reads the ram and then answers; print gives count results on consecutive cycles.
// one transaction at a time: start is accepted only while idle, so no new transaction is taken while busy.
// reset clears state and count; ram contents stay undefined.
module positional_char_list
  import pcl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [CHAR_W-1:0] char_in_i,
  output logic              valid_o,
  output logic [1:0]        status_o,
  output logic [CHAR_W-1:0] char_out_o,
  output logic              char_valid_o,
  output logic              last_o
);

  state_e              state_q, state_d;
  mode_e               op_q, op_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ADDR_W-1:0]   idx_q, idx_d;
  logic [ADDR_W-1:0]   pos_q, pos_d;
  logic [CHAR_W-1:0]   ch_q, ch_d;

  logic                valid_q, valid_d;
  status_e             status_q, status_d;
  logic [CHAR_W-1:0]   char_q, char_d;
  logic                cv_q, cv_d;
  logic                last_q, last_d;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [CHAR_W-1:0]   ram_wdata, ram_rdata;

  logic                accept;
  logic [CMP_W-1:0]    pos_w, cnt_w;
  logic                add_bad, pos_bad, full;
  logic                add_at_tail, del_at_tail;
  logic                add_shift_end, del_shift_end, print_end;

  assign accept  = start && (state_q == S_IDLE);
  assign pos_w   = CMP_W'(position_i);
  assign cnt_w   = CMP_W'(cnt_q);
  assign add_bad = (position_i == '0) || (pos_w > cnt_w + CMP_W'(1));
  assign pos_bad = (position_i == '0) || (pos_w > cnt_w);
  assign full    = (cnt_q == CNT_W'(CAPACITY));
  assign add_at_tail = (pos_w == cnt_w + CMP_W'(1));
  assign del_at_tail = (pos_w == cnt_w);
  // shift walks stop one short of the target entry
  assign add_shift_end = ((idx_q - ADDR_W'(1)) == pos_q);
  assign del_shift_end = ((idx_q + ADDR_W'(1)) == ADDR_W'(cnt_q - CNT_W'(1)));
  assign print_end     = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

  pcl_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_e'(mode_i))
            MODE_ADD: begin
              if (!add_bad && !full) begin
                state_d = add_at_tail ? S_INS_WR : S_SHIFT;
              end
            end
            MODE_DEL: begin
              if (!pos_bad && !del_at_tail) begin
                state_d = S_SHIFT;
              end
            end
            MODE_GET: begin
              if (!pos_bad) begin
                state_d = S_GET;
              end
            end
            MODE_PRINT: begin
              if (cnt_q != '0) begin
                state_d = S_PRINT;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SHIFT: begin
        if (op_q == MODE_ADD) begin
          if (add_shift_end) begin
            state_d = S_INS_WR;
          end
        end else if (del_shift_end) begin
          state_d = S_IDLE;
        end
      end
      S_INS_WR: state_d = S_IDLE;
      S_GET:    state_d = S_IDLE;
      S_PRINT: begin
        if (print_end) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    op_d      = op_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    ch_d      = ch_q;
    valid_d   = 1'b0;
    status_d  = ST_OK;
    char_d    = '0;
    cv_d      = 1'b0;
    last_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ram_rdata;
    ram_raddr = idx_q + ADDR_W'(1);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = mode_e'(mode_i);
          ch_d  = char_in_i;
          pos_d = ADDR_W'(position_i - POS_W'(1));
          unique case (mode_e'(mode_i))
            MODE_ADD: begin
              if (add_bad) begin
                valid_d  = 1'b1;
                status_d = ST_BAD_POS;
                last_d   = 1'b1;
              end else if (full) begin
                valid_d  = 1'b1;
                status_d = ST_FULL;
                last_d   = 1'b1;
              end else begin
                idx_d     = ADDR_W'(cnt_q);
                ram_raddr = ADDR_W'(cnt_q - CNT_W'(1));
              end
            end
            MODE_DEL: begin
              if (pos_bad) begin
                valid_d  = 1'b1;
                status_d = ST_BAD_POS;
                last_d   = 1'b1;
              end else if (del_at_tail) begin
                cnt_d   = cnt_q - CNT_W'(1);
                valid_d = 1'b1;
                last_d  = 1'b1;
              end else begin
                idx_d     = ADDR_W'(position_i - POS_W'(1));
                ram_raddr = ADDR_W'(position_i);
              end
            end
            MODE_GET: begin
              if (pos_bad) begin
                valid_d  = 1'b1;
                status_d = ST_BAD_POS;
                last_d   = 1'b1;
              end else begin
                ram_raddr = ADDR_W'(position_i - POS_W'(1));
              end
            end
            MODE_PRINT: begin
              if (cnt_q == '0) begin
                valid_d = 1'b1;
                last_d  = 1'b1;
              end else begin
                idx_d     = '0;
                ram_raddr = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        // write the entry read last cycle, read the next one behind it
        ram_we = 1'b1;
        if (op_q == MODE_ADD) begin
          idx_d     = idx_q - ADDR_W'(1);
          ram_raddr = idx_q - ADDR_W'(2);
        end else begin
          idx_d     = idx_q + ADDR_W'(1);
          ram_raddr = idx_q + ADDR_W'(2);
          if (del_shift_end) begin
            cnt_d   = cnt_q - CNT_W'(1);
            valid_d = 1'b1;
            last_d  = 1'b1;
          end
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = ch_q;
        cnt_d     = cnt_q + CNT_W'(1);
        valid_d   = 1'b1;
        last_d    = 1'b1;
      end
      S_GET: begin
        valid_d = 1'b1;
        char_d  = ram_rdata;
        cv_d    = 1'b1;
        last_d  = 1'b1;
      end
      S_PRINT: begin
        valid_d = 1'b1;
        char_d  = ram_rdata;
        cv_d    = 1'b1;
        last_d  = print_end;
        idx_d   = idx_q + ADDR_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    ch_q     <= ch_d;
    status_q <= status_d;
    char_q   <= char_d;
    cv_q     <= cv_d;
    last_q   <= last_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign char_out_o   = char_q;
  assign char_valid_o = cv_q;
  assign last_o       = last_q;

endmodule

// ===== design/pcl_checker.sv =====
// port-level checker for positional_char_list, attached by bind
// depends on pcl_pkg for widths and status codes
module pcl_checker
  import pcl_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              valid_o,
  input logic [1:0]        status_o,
  input logic [CHAR_W-1:0] char_out_o,
  input logic              char_valid_o,
  input logic              last_o
);

  // an accepted transaction shows a result or keeps the block busy next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> valid_o || busy)
    else $error("accepted transaction made no progress");

  // print results come back to back until the last one
  a_print_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("gap inside print burst");

  // idle while showing a result only on the final one
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !busy |-> last_o)
    else $error("block idle before final result");

  // error status is a single result carrying no character
  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o != ST_OK) |-> last_o && !char_valid_o && (char_out_o == '0))
    else $error("error result malformed");

  // a character is only carried with ok status
  a_char_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && char_valid_o |-> (status_o == ST_OK))
    else $error("character with error status");

endmodule

bind positional_char_list pcl_checker u_pcl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .valid_o      (valid_o),
  .status_o     (status_o),
  .char_out_o   (char_out_o),
  .char_valid_o (char_valid_o),
  .last_o       (last_o)
);
